// ===== design/circular_double_ended_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Circular deque assertion macros
// Shared property forms for the deque checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CDEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cdeq_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular deque package
// Request and status codes, word type and the per-cycle cell command.
// ----------------------------------------------------------------------------
package cdeq_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam word_t POP_FAIL_WORD = '1;
    localparam word_t PUSH_RESULT_WORD = '0;

    // command broadcast to every cell; only set when the request succeeds
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } cell_op_t;

endpackage

// ===== design/circular_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Circular double-ended queue
// Deque of signed 32-bit words built as a chain of DEPTH shifting cells.
// ----------------------------------------------------------------------------
// An item is accepted whenever the result register is empty or being
// drained, so the block sustains one item per cycle while results are
// taken downstream. The front word always sits in cell 0 and every cell
// shifts toward its neighbor in the same cycle, so pushes and pops at the
// front are one chain update; rear pushes fill the first free cell and rear
// pops clear the last valid cell, whose word each cell presents on a tap that
// is ORed into the result. Full and empty come straight from the valid bits
// of the end cells, so there is no fill counter and nothing to clear after
// reset. The result (word and status) appears in the output register in the
// cycle after the item is accepted.
module circular_double_ended_queue #(
    parameter int DEPTH = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_push_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pop_word,
    output logic [1:0]         m_status
);
    import cdeq_pkg::*;

    logic     valid_w [DEPTH];
    word_t    word_w  [DEPTH];
    word_t    tap_w   [DEPTH];
    word_t    rear_word;
    logic     accept, full, empty;
    req_t     req;
    cell_op_t op;
    word_t    res_word;
    status_t  res_status;

    assign accept = s_valid & s_ready;
    assign req    = req_t'(s_req_type);
    assign full   = valid_w[DEPTH-1];
    assign empty  = ~valid_w[0];

    always_comb begin
        op         = '0;
        res_word   = PUSH_RESULT_WORD;
        res_status = ST_OK;
        unique case (req)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    op.push_front = accept & (req == REQ_PUSH_FRONT);
                    op.push_rear  = accept & (req == REQ_PUSH_REAR);
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    res_word   = POP_FAIL_WORD;
                    res_status = ST_EMPTY;
                end else begin
                    res_word     = word_w[0];
                    op.pop_front = accept;
                end
            end
            REQ_POP_REAR: begin
                if (empty) begin
                    res_word   = POP_FAIL_WORD;
                    res_status = ST_EMPTY;
                end else begin
                    res_word    = rear_word;
                    op.pop_rear = accept;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    // exactly one cell is last when non-empty
    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | tap_w[i];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic  lv, rv;
        word_t lw, rw;
        if (g == 0) begin : g_head
            assign lv = 1'b1;
            assign lw = s_push_word;
        end else begin : g_mid
            assign lv = valid_w[g-1];
            assign lw = word_w[g-1];
        end
        if (g == DEPTH-1) begin : g_end
            assign rv = 1'b0;
            assign rw = '0;
        end else begin : g_body
            assign rv = valid_w[g+1];
            assign rw = word_w[g+1];
        end
        cdeq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (op),
            .push_word   (s_push_word),
            .left_valid  (lv),
            .left_word   (lw),
            .right_valid (rv),
            .right_word  (rw),
            .valid       (valid_w[g]),
            .word        (word_w[g]),
            .rear_tap    (tap_w[g])
        );
    end

    cdeq_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .pop_word   (res_word),
        .status     (res_status),
        .can_load   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pop_word (m_pop_word),
        .m_status   (m_status)
    );

endmodule

// ===== design/cdeq_cell.sv =====
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the chain: holds a word and a valid bit, shifts toward either
// neighbor, and shows its word on the rear tap when it is the last valid slot.
// ----------------------------------------------------------------------------
module cdeq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  cdeq_pkg::cell_op_t op,
    input  cdeq_pkg::word_t   push_word,
    input  logic              left_valid,
    input  cdeq_pkg::word_t   left_word,
    input  logic              right_valid,
    input  cdeq_pkg::word_t   right_word,
    output logic              valid,
    output cdeq_pkg::word_t   word,
    output cdeq_pkg::word_t   rear_tap
);
    import cdeq_pkg::*;

    logic  valid_reg, valid_next;
    word_t word_reg, word_next;
    logic  is_last;

    assign is_last = valid_reg & ~right_valid;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (op.push_front) begin
            valid_next = left_valid;
            word_next  = left_word;
        end else if (op.push_rear) begin
            // first free slot takes the incoming word
            if (!valid_reg && left_valid) begin
                valid_next = 1'b1;
                word_next  = push_word;
            end
        end else if (op.pop_front) begin
            valid_next = right_valid;
            word_next  = right_word;
        end else if (op.pop_rear) begin
            if (is_last) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign valid    = valid_reg;
    assign word     = word_reg;
    assign rear_tap = is_last ? word_reg : '0;

endmodule

// ===== design/cdeq_out_reg.sv =====
// ----------------------------------------------------------------------------
// Deque result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module cdeq_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  cdeq_pkg::word_t        pop_word,
    input  cdeq_pkg::status_t      status,
    output logic                   can_load,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_pop_word,
    output logic [1:0]             m_status
);
    import cdeq_pkg::*;

    logic    valid_reg, valid_next;
    word_t   word_reg;
    status_t status_reg;

    assign can_load = ~valid_reg | m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg   <= pop_word;
            status_reg <= status;
        end
    end

    assign m_valid    = valid_reg;
    assign m_pop_word = word_reg;
    assign m_status   = status_reg;

endmodule

// ===== design/cdeq_checker.sv =====
// ----------------------------------------------------------------------------
// Deque port checker
// Watches the top-level ports for result and flow-control rules.
// ----------------------------------------------------------------------------
`include "circular_double_ended_queue_macros.svh"

module cdeq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_pop_word,
    input logic [1:0]         m_status
);
    import cdeq_pkg::*;

    `CDEQ_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid, "result item dropped before taken")
    `CDEQ_ASSERT_IMPLY(a_stall_only_on_result, aclk, aresetn, !s_ready, m_valid, "input stalled with no pending result")
    `CDEQ_ASSERT_IMPLY(a_failed_pop_word, aclk, aresetn, m_valid && m_status == ST_EMPTY, m_pop_word == POP_FAIL_WORD, "failed pop must return all ones")
    `CDEQ_ASSERT_IMPLY(a_dropped_push_word, aclk, aresetn, m_valid && m_status == ST_FULL, m_pop_word == PUSH_RESULT_WORD, "dropped push must return zero")
    `CDEQ_ASSERT_NEXT(a_result_follows_accept, aclk, aresetn, s_valid && s_ready, m_valid, "accepted item gave no result")

endmodule

bind circular_double_ended_queue cdeq_checker u_cdeq_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_pop_word (m_pop_word),
    .m_status   (m_status)
);
